/* rtl/pbw_pkg.sv */
// Package for the perspective barycentric weight block.
// Holds the default weight format shared by the top level and its testbench.
// No dependencies.
package pbw_pkg;

	// Fractional bits of the weight format (Q2.14 by default).
	localparam int unsigned WEIGHT_FRAC_BITS = 14;

	// Width of one packed field on the streams.
	localparam int unsigned FIELD_W = 16;

	// Saturation bounds of a signed field.
	localparam int signed SAT_MAX = 32767;
	localparam int signed SAT_MIN = -32768;

endpackage

/* rtl/pbw_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband vector alongside each operand pair. Uses no package items.
module pbw_div #(
	parameter int unsigned NUM_W  = 50,
	parameter int unsigned DEN_W  = 35,
	parameter int unsigned USER_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [USER_W-1:0] in_user,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [USER_W-1:0] out_user
);

	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  nq_s   [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [USER_W-1:0] user_s [NUM_W];
	logic              vld_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0]  prev_rem;
		logic [NUM_W-1:0]  prev_nq;
		logic [DEN_W-1:0]  prev_den;
		logic [USER_W-1:0] prev_user;
		logic              prev_vld;
		logic [DEN_W:0]    r_ext;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign prev_rem  = '0;
			assign prev_nq   = in_num;
			assign prev_den  = in_den;
			assign prev_user = in_user;
			assign prev_vld  = in_valid;
		end else begin : g_next
			assign prev_rem  = rem_s[k-1];
			assign prev_nq   = nq_s[k-1];
			assign prev_den  = den_s[k-1];
			assign prev_user = user_s[k-1];
			assign prev_vld  = vld_s[k-1];
		end

		// Bring down the next numerator bit and try one subtraction.
		assign r_ext = {prev_rem, prev_nq[NUM_W-1]};
		assign diff  = r_ext - {1'b0, prev_den};
		assign ge    = (r_ext >= {1'b0, prev_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= prev_vld;
			end
		end

		// The numerator shifts out at the top while quotient bits enter below.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DEN_W-1:0] : r_ext[DEN_W-1:0];
				nq_s[k]   <= {prev_nq[NUM_W-2:0], ge};
				den_s[k]  <= prev_den;
				user_s[k] <= prev_user;
			end
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign out_quo   = nq_s[NUM_W-1];
	assign out_user  = user_s[NUM_W-1];

endmodule

/* rtl/perspective_barycentric_weights.sv */
// Top level of the perspective-correct barycentric weight pipeline.
// Depends on pbw_pkg and on the pipelined divider pbw_div.
//
// Usage: each input word on s_tdata carries one triangle (three vertices with
// x, y and w) and one sample point. Each accepted word gives exactly one
// output word on m_tdata with screen weights, perspective weights, the inside
// flag and the degenerate flag. A new word may be accepted in every cycle
// while s_tready is high. A word passes stages 1 to 4, the screen dividers,
// stages 5 to 8, the perspective dividers, stage 9 and the output register;
// each divider resolves one quotient bit per stage (Q2.14 weights by default).
// cfg_we writes the inside margin; write it only while the pipeline is empty.
// Reset clears all valid bits and the margin; no word is in flight after it.
// When m_tready is low, the output register holds its word and a one-word
// skid register catches the next result; s_tready then drops and the whole
// pipeline freezes until the skid register drains. Nothing is lost or
// repeated under any stall pattern on either side.
module perspective_barycentric_weights #(
	parameter int unsigned WEIGHT_FRAC_BITS = pbw_pkg::WEIGHT_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	// Fields from bit 0 up: vert0_x, vert0_y, vert0_w, vert1_x, vert1_y,
	// vert1_w, vert2_x, vert2_y, vert2_w, pixel_x, pixel_y (16 bits each).
	input  logic [175:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0 up: screen_w0, screen_w1, screen_w2, persp_w0,
	// persp_w1, persp_w2 (16 bits each), inside_res, degenerate, zero pad.
	output logic [103:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic [14:0]  cfg_wdata
);

	localparam int unsigned W       = WEIGHT_FRAC_BITS;
	localparam int unsigned FW      = pbw_pkg::FIELD_W;
	localparam int unsigned NUM1_W  = W + 36;
	localparam int unsigned DEN1_W  = 35;
	localparam int unsigned NUM2_W  = W + 34;
	localparam int unsigned DEN2_W  = 34;
	localparam int unsigned U1_W    = 3 * FW + 2;
	localparam int unsigned U2_W    = 3 * FW + 2;
	localparam int unsigned SUM1_W  = NUM1_W + 3;
	localparam int unsigned Q2S_W   = NUM2_W + 1;

	logic en;
	logic [14:0] margin_q;

	// Clamp a wide signed value to the 16-bit field range.
	function automatic logic [FW-1:0] sat1(input logic signed [SUM1_W-1:0] v);
		logic [FW-1:0] r;
		if (v > $signed(SUM1_W'(pbw_pkg::SAT_MAX))) r = FW'(pbw_pkg::SAT_MAX);
		else if (v < $signed(SUM1_W'(pbw_pkg::SAT_MIN))) r = FW'(pbw_pkg::SAT_MIN);
		else r = v[FW-1:0];
		return r;
	endfunction

	function automatic logic [FW-1:0] sat2(input logic signed [Q2S_W-1:0] v);
		logic [FW-1:0] r;
		if (v > $signed(Q2S_W'(pbw_pkg::SAT_MAX))) r = FW'(pbw_pkg::SAT_MAX);
		else if (v < $signed(Q2S_W'(pbw_pkg::SAT_MIN))) r = FW'(pbw_pkg::SAT_MIN);
		else r = v[FW-1:0];
		return r;
	endfunction

	// Margin register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	// Stage 1: edge vectors relative to vertex 0.
	logic signed [16:0] abx_s1, aby_s1, acx_s1, acy_s1, apx_s1, apy_s1;
	logic [47:0] w_s1;
	logic vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			abx_s1 <= $signed({s_tdata[63], s_tdata[63:48]})
				- $signed({s_tdata[15], s_tdata[15:0]});
			aby_s1 <= $signed({s_tdata[79], s_tdata[79:64]})
				- $signed({s_tdata[31], s_tdata[31:16]});
			acx_s1 <= $signed({s_tdata[111], s_tdata[111:96]})
				- $signed({s_tdata[15], s_tdata[15:0]});
			acy_s1 <= $signed({s_tdata[127], s_tdata[127:112]})
				- $signed({s_tdata[31], s_tdata[31:16]});
			apx_s1 <= $signed({s_tdata[159], s_tdata[159:144]})
				- $signed({s_tdata[15], s_tdata[15:0]});
			apy_s1 <= $signed({s_tdata[175], s_tdata[175:160]})
				- $signed({s_tdata[31], s_tdata[31:16]});
			w_s1   <= {s_tdata[143:128], s_tdata[95:80], s_tdata[47:32]};
		end
	end

	// Stage 2: the six cross-product terms.
	logic signed [33:0] a0_s2, a1_s2, b0_s2, b1_s2, c0_s2, c1_s2;
	logic [47:0] w_s2;
	logic vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s2 <= abx_s1 * acy_s1;
			a1_s2 <= aby_s1 * acx_s1;
			b0_s2 <= acy_s1 * apx_s1;
			b1_s2 <= acx_s1 * apy_s1;
			c0_s2 <= abx_s1 * apy_s1;
			c1_s2 <= aby_s1 * apx_s1;
			w_s2  <= w_s1;
		end
	end

	// Stage 3: the doubled signed area and the edge functions for s and t.
	logic signed [34:0] area_s3, sn_s3, tn_s3;
	logic [47:0] w_s3;
	logic vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			area_s3 <= 35'(a0_s2) - 35'(a1_s2);
			sn_s3   <= 35'(b0_s2) - 35'(b1_s2);
			tn_s3   <= 35'(c0_s2) - 35'(c1_s2);
			w_s3    <= w_s2;
		end
	end

	// Stage 4: rounded division operands, (2|n|*2^W + |d|) / (2|d|).
	logic [34:0] a_abs, s_abs, t_abs;
	logic [NUM1_W-1:0] num_s_s4, num_t_s4;
	logic [DEN1_W-1:0] den1_s4;
	logic [U1_W-1:0] user1_s4;
	logic t_neg_s4;
	logic vld_s4;

	assign a_abs = area_s3[34] ? 35'(-area_s3) : 35'(area_s3);
	assign s_abs = sn_s3[34] ? 35'(-sn_s3) : 35'(sn_s3);
	assign t_abs = tn_s3[34] ? 35'(-tn_s3) : 35'(tn_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s_s4 <= (NUM1_W'(s_abs[33:0]) << (W + 1)) + NUM1_W'(a_abs[33:0]);
			num_t_s4 <= (NUM1_W'(t_abs[33:0]) << (W + 1)) + NUM1_W'(a_abs[33:0]);
			den1_s4  <= {a_abs[33:0], 1'b0};
			user1_s4 <= {w_s3, (area_s3 == '0), sn_s3[34] ^ area_s3[34]};
			t_neg_s4 <= tn_s3[34] ^ area_s3[34];
		end
	end

	// Screen weight divisions.
	logic vld_d1;
	logic [NUM1_W-1:0] q_s, q_t;
	logic [U1_W-1:0] user1_d;
	logic t_neg_d;

	pbw_div #(.NUM_W(NUM1_W), .DEN_W(DEN1_W), .USER_W(U1_W)) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.in_num(num_s_s4), .in_den(den1_s4), .in_user(user1_s4),
		.out_valid(vld_d1), .out_quo(q_s), .out_user(user1_d)
	);

	pbw_div #(.NUM_W(NUM1_W), .DEN_W(DEN1_W), .USER_W(1)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.in_num(num_t_s4), .in_den(den1_s4), .in_user(t_neg_s4),
		.out_valid(), .out_quo(q_t), .out_user(t_neg_d)
	);

	// Stage 5: signed screen weights, u = one - s - t, saturated.
	logic signed [SUM1_W-1:0] s_val, t_val, u_val;
	logic [FW-1:0] sw0_s5, sw1_s5, sw2_s5;
	logic [47:0] w_s5;
	logic azero_s5;
	logic vld_s5;

	assign s_val = user1_d[0] ? -$signed(SUM1_W'(q_s)) : $signed(SUM1_W'(q_s));
	assign t_val = t_neg_d ? -$signed(SUM1_W'(q_t)) : $signed(SUM1_W'(q_t));
	assign u_val = $signed(SUM1_W'(1) << W) - s_val - t_val;

	always_ff @(posedge clk) begin
		if (en) begin
			sw0_s5   <= sat1(u_val);
			sw1_s5   <= sat1(s_val);
			sw2_s5   <= sat1(t_val);
			w_s5     <= user1_d[U1_W-1:2];
			azero_s5 <= user1_d[1];
		end
	end

	// Stage 6: w-scaled weights.
	logic signed [32:0] p0_s6, p1_s6, p2_s6;
	logic [FW-1:0] sw0_s6, sw1_s6, sw2_s6;
	logic azero_s6;
	logic vld_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s6    <= $signed({1'b0, w_s5[15:0]}) * $signed(sw0_s5);
			p1_s6    <= $signed({1'b0, w_s5[31:16]}) * $signed(sw1_s5);
			p2_s6    <= $signed({1'b0, w_s5[47:32]}) * $signed(sw2_s5);
			sw0_s6   <= sw0_s5;
			sw1_s6   <= sw1_s5;
			sw2_s6   <= sw2_s5;
			azero_s6 <= azero_s5;
		end
	end

	// Stage 7: normalizer and degenerate decision.
	logic signed [34:0] nsum;
	logic signed [34:0] n_s7;
	logic signed [32:0] p0_s7, p1_s7, p2_s7;
	logic [FW-1:0] sw0_s7, sw1_s7, sw2_s7;
	logic degen_s7;
	logic vld_s7;

	assign nsum = 35'(p0_s6) + 35'(p1_s6) + 35'(p2_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s7     <= nsum;
			p0_s7    <= p0_s6;
			p1_s7    <= p1_s6;
			p2_s7    <= p2_s6;
			sw0_s7   <= sw0_s6;
			sw1_s7   <= sw1_s6;
			sw2_s7   <= sw2_s6;
			degen_s7 <= azero_s6 || (nsum == '0);
		end
	end

	// Stage 8: rounded division operands for the three perspective weights.
	logic [34:0] n_abs;
	logic [32:0] p0_abs, p1_abs, p2_abs;
	logic [NUM2_W-1:0] num0_s8, num1_s8, num2_s8;
	logic [DEN2_W-1:0] den2_s8;
	logic [U2_W-1:0] user2_s8;
	logic neg1_s8, neg2_s8;
	logic vld_s8;

	assign n_abs  = n_s7[34] ? 35'(-n_s7) : 35'(n_s7);
	assign p0_abs = p0_s7[32] ? 33'(-p0_s7) : 33'(p0_s7);
	assign p1_abs = p1_s7[32] ? 33'(-p1_s7) : 33'(p1_s7);
	assign p2_abs = p2_s7[32] ? 33'(-p2_s7) : 33'(p2_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s8  <= (NUM2_W'(p0_abs[31:0]) << (W + 1)) + NUM2_W'(n_abs[32:0]);
			num1_s8  <= (NUM2_W'(p1_abs[31:0]) << (W + 1)) + NUM2_W'(n_abs[32:0]);
			num2_s8  <= (NUM2_W'(p2_abs[31:0]) << (W + 1)) + NUM2_W'(n_abs[32:0]);
			den2_s8  <= {n_abs[32:0], 1'b0};
			user2_s8 <= {sw2_s7, sw1_s7, sw0_s7, degen_s7, p0_s7[32] ^ n_s7[34]};
			neg1_s8  <= p1_s7[32] ^ n_s7[34];
			neg2_s8  <= p2_s7[32] ^ n_s7[34];
		end
	end

	// Perspective weight divisions.
	logic vld_d2;
	logic [NUM2_W-1:0] q0, q1, q2;
	logic [U2_W-1:0] user2_d;
	logic neg1_d, neg2_d;

	pbw_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .USER_W(U2_W)) u_div_p0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s8),
		.in_num(num0_s8), .in_den(den2_s8), .in_user(user2_s8),
		.out_valid(vld_d2), .out_quo(q0), .out_user(user2_d)
	);

	pbw_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .USER_W(1)) u_div_p1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s8),
		.in_num(num1_s8), .in_den(den2_s8), .in_user(neg1_s8),
		.out_valid(), .out_quo(q1), .out_user(neg1_d)
	);

	pbw_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .USER_W(1)) u_div_p2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s8),
		.in_num(num2_s8), .in_den(den2_s8), .in_user(neg2_s8),
		.out_valid(), .out_quo(q2), .out_user(neg2_d)
	);

	// Stage 9: saturated perspective weights, inside test, output word.
	logic [FW-1:0] pw0, pw1, pw2;
	logic signed [16:0] neg_margin;
	logic inside_ok;
	logic degen_d;
	logic [103:0] word_s9;
	logic vld_s9;

	assign pw0 = sat2(user2_d[0] ? -$signed(Q2S_W'(q0)) : $signed(Q2S_W'(q0)));
	assign pw1 = sat2(neg1_d ? -$signed(Q2S_W'(q1)) : $signed(Q2S_W'(q1)));
	assign pw2 = sat2(neg2_d ? -$signed(Q2S_W'(q2)) : $signed(Q2S_W'(q2)));
	assign neg_margin = -$signed({2'b00, margin_q});
	assign degen_d = user2_d[1];
	assign inside_ok = ($signed({pw0[15], pw0}) >= neg_margin)
		&& ($signed({pw1[15], pw1}) >= neg_margin)
		&& ($signed({pw2[15], pw2}) >= neg_margin);

	always_ff @(posedge clk) begin
		if (en) begin
			if (degen_d) begin
				word_s9 <= {6'b0, 1'b1, 1'b0, 96'b0};
			end else begin
				word_s9 <= {6'b0, 1'b0, inside_ok, pw2, pw1, pw0, user2_d[U2_W-1:2]};
			end
		end
	end

	// Valid bits of the top-level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_d1;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_d2;
		end
	end

	// Output register with a one-word skid register behind it.
	logic [103:0] out_data_q, skid_data_q;
	logic out_valid_q, skid_full_q;

	assign en       = !skid_full_q;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= vld_s9;
			end
		end else if (vld_s9 && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_full_q ? skid_data_q : word_s9;
		end else if (vld_s9 && !skid_full_q) begin
			skid_data_q <= word_s9;
		end
	end

`ifndef SYNTHESIS
	// The skid register only fills behind a stalled output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid word held without an output word");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid register filled without a stall");

	// A degenerate word never reports inside and carries zero weights.
	a_degen_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[97]) |-> (out_data_q[96:0] == '0))
		else $error("degenerate word with nonzero fields");
`endif

endmodule

/* verif/tb_perspective_barycentric_weights.sv */
`timescale 1ns / 1ps
// Testbench for perspective_barycentric_weights: random and directed pixel queries,
// with a scoreboard class that predicts each output word. Depends on pbw_pkg and the RTL.
module tb_perspective_barycentric_weights;

	localparam int FRAC = pbw_pkg::WEIGHT_FRAC_BITS;
	localparam int LATENCY = 2 * FRAC + 79;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] pix_y, pix_x;
		logic [15:0] w2, y2, x2;
		logic [15:0] w1, y1, x1;
		logic [15:0] w0, y0, x0;
	} query_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic        degenerate;
		logic        inside_res;
		logic [15:0] pw2, pw1, pw0;
		logic [15:0] sw2, sw1, sw0;
	} weights_t;

	// Predicts the weight word for each accepted query and checks results in order.
	class weight_scoreboard;
		weights_t pending[$];
		longint margin;
		int errors;

		function new();
			margin = 0;
			errors = 0;
		endfunction

		static function longint round_div(longint num, longint den);
			longint un, ud, q;
			un = num < 0 ? -num : num;
			ud = den < 0 ? -den : den;
			q = (2 * un + ud) / (2 * ud);
			return ((num < 0) != (den < 0)) ? -q : q;
		endfunction

		static function longint clamp16(longint v);
			if (v > pbw_pkg::SAT_MAX) return pbw_pkg::SAT_MAX;
			if (v < pbw_pkg::SAT_MIN) return pbw_pkg::SAT_MIN;
			return v;
		endfunction

		function void note_query(query_t q);
			weights_t r;
			longint one, abx, aby, acx, acy, apx, apy, area, s, t, norm;
			longint sw[3], pw[3], pr[3], wv[3];
			one = longint'(1) << FRAC;
			r = '0;
			abx = longint'($signed(q.x1)) - longint'($signed(q.x0));
			aby = longint'($signed(q.y1)) - longint'($signed(q.y0));
			acx = longint'($signed(q.x2)) - longint'($signed(q.x0));
			acy = longint'($signed(q.y2)) - longint'($signed(q.y0));
			apx = longint'($signed(q.pix_x)) - longint'($signed(q.x0));
			apy = longint'($signed(q.pix_y)) - longint'($signed(q.y0));
			wv[0] = longint'(q.w0);
			wv[1] = longint'(q.w1);
			wv[2] = longint'(q.w2);
			area = abx * acy - aby * acx;
			if (area == 0) begin
				r.degenerate = 1'b1;
				pending.push_back(r);
				return;
			end
			s = round_div((acy * apx - acx * apy) * one, area);
			t = round_div((abx * apy - aby * apx) * one, area);
			sw[0] = clamp16(one - s - t);
			sw[1] = clamp16(s);
			sw[2] = clamp16(t);
			norm = 0;
			for (int i = 0; i < 3; i++) begin
				pr[i] = wv[i] * sw[i];
				norm += pr[i];
			end
			if (norm == 0) begin
				r.degenerate = 1'b1;
				pending.push_back(r);
				return;
			end
			r.inside_res = 1'b1;
			for (int i = 0; i < 3; i++) begin
				pw[i] = clamp16(round_div(pr[i] * one, norm));
				if (pw[i] < -margin) r.inside_res = 1'b0;
			end
			r.sw0 = 16'(sw[0]); r.sw1 = 16'(sw[1]); r.sw2 = 16'(sw[2]);
			r.pw0 = 16'(pw[0]); r.pw1 = 16'(pw[1]); r.pw2 = 16'(pw[2]);
			pending.push_back(r);
		endfunction

		function void check_word(weights_t got);
			weights_t exp;
			if (pending.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.sw0 !== exp.sw0) begin $error("screen_w0 exp %h got %h", exp.sw0, got.sw0); errors++; end
			if (got.sw1 !== exp.sw1) begin $error("screen_w1 exp %h got %h", exp.sw1, got.sw1); errors++; end
			if (got.sw2 !== exp.sw2) begin $error("screen_w2 exp %h got %h", exp.sw2, got.sw2); errors++; end
			if (got.pw0 !== exp.pw0) begin $error("persp_w0 exp %h got %h", exp.pw0, got.pw0); errors++; end
			if (got.pw1 !== exp.pw1) begin $error("persp_w1 exp %h got %h", exp.pw1, got.pw1); errors++; end
			if (got.pw2 !== exp.pw2) begin $error("persp_w2 exp %h got %h", exp.pw2, got.pw2); errors++; end
			if (got.inside_res !== exp.inside_res) begin
				$error("inside_res exp %b got %b", exp.inside_res, got.inside_res); errors++;
			end
			if (got.degenerate !== exp.degenerate) begin
				$error("degenerate exp %b got %b", exp.degenerate, got.degenerate); errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [175:0] s_tdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] m_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic         cfg_we = 1'b0;
	logic [14:0]  cfg_wdata = '0;

	weight_scoreboard board = new();
	int  hold_cycles = 0;      // long receiver hold-off, consumed by the receiver
	int  quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	perspective_barycentric_weights DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Check every accepted output word.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_word(weights_t'(m_tdata));
	end

	// Watchdog: cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: random stalls per word, plus a long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_query(query_t q, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= q;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_query(q);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_margin(logic [14:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.margin = longint'(value);
	endtask

	function automatic query_t make_triangle(int span);
		query_t q;
		q = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		q.x0 = 16'($urandom_range(0, 2 * span) - span);
		q.y0 = 16'($urandom_range(0, 2 * span) - span);
		q.x1 = 16'($urandom_range(0, 2 * span) - span);
		q.y1 = 16'($urandom_range(0, 2 * span) - span);
		q.x2 = 16'($urandom_range(0, 2 * span) - span);
		q.y2 = 16'($urandom_range(0, 2 * span) - span);
		q.pix_x = 16'($urandom_range(0, 2 * span) - span);
		q.pix_y = 16'($urandom_range(0, 2 * span) - span);
		if ($urandom_range(0, 3) != 0) begin
			q.w0 = 16'($urandom_range(1, 32768));
			q.w1 = 16'($urandom_range(1, 32768));
			q.w2 = 16'($urandom_range(1, 32768));
		end
		return q;
	endfunction

	function automatic query_t random_query();
		query_t q;
		case ($urandom_range(0, 9))
			0: q = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			1: begin
				// Collinear vertices give a zero area.
				q = make_triangle(2000);
				q.x1 = q.x0; q.x2 = q.x0;
			end
			2: q = make_triangle(32767);
			default: q = make_triangle($urandom_range(0, 3) == 0 ? 64 : 1200);
		endcase
		return q;
	endfunction

	initial begin
		query_t q;
		logic [14:0] margins[5];
		margins = '{15'd0, 15'd16384, 15'd32767, 15'd200, 15'd1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero area, zero normalizer, inside and outside points.
		q = '0; send_query(q, 0);
		q = '1; send_query(q, 0);
		q = '0; q.x1 = 16'd160; q.y2 = 16'd160; q.pix_x = 16'd40; q.pix_y = 16'd40;
		q.w0 = 16'd16384; q.w1 = 16'd16384; q.w2 = 16'd16384; send_query(q, 0);
		q.pix_x = 16'hFF00; send_query(q, 1);
		q.w0 = 16'hFFFF; q.w1 = 16'd1; q.w2 = 16'hFFFF; send_query(q, 0);
		q.w0 = 16'd0; q.w1 = 16'd0; q.w2 = 16'd0; send_query(q, 0);
		q.pix_x = 16'd0; q.pix_y = 16'd0; q.w0 = 16'd0; q.w1 = 16'd5; send_query(q, 2);
		q = '0; q.x0 = 16'h8000; q.y0 = 16'h8000; q.x1 = 16'h7FFF; q.y1 = 16'h8000;
		q.x2 = 16'h8000; q.y2 = 16'h7FFF; q.pix_x = 16'h7FFF; q.pix_y = 16'h7FFF;
		q.w0 = 16'hFFFF; q.w1 = 16'hFFFF; q.w2 = 16'hFFFF; send_query(q, 0);
		q.pix_x = 16'h8000; q.pix_y = 16'h7FFF; send_query(q, 0);
		q = '0; q.x1 = 16'd1; q.y2 = 16'd1; q.pix_x = 16'h7FFF; q.pix_y = 16'h8000;
		q.w0 = 16'd1; q.w1 = 16'hFFFF; q.w2 = 16'd1; send_query(q, 0);
		q.x1 = 16'd0; q.y1 = 16'd0; send_query(q, 0);
		for (int i = 0; i < 8; i++) send_query(random_query(), 0);
		drain();

		// Random phases, one per margin setting.
		for (int ph = 0; ph < 5; ph++) begin
			write_margin(margins[ph]);
			for (int n = 0; n < 200; n++) begin
				if (ph == 1 && n == 20) hold_cycles = 400;
				if (ph == 3 && n == 100) begin
					// Sender waits for every result before going on.
					s_tvalid <= 1'b0;
					while (board.pending.size() != 0) @(posedge clk);
				end
				send_query(random_query(), ($urandom_range(0, 2) == 0) ? 0 :
					$urandom_range(0, 12));
			end
			drain();
		end

		if (board.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
